### rtl/psdp_pkg.sv
// Package for the diffraction pixel phasor-sum block: widths, limits,
// register indexes, FSM state type and the CORDIC arctangent table. No dependencies.
`default_nettype none
package psdp_pkg;
    localparam int GRID_MAX   = 256;
    localparam int PHASE_BITS = 16;
    localparam int GW         = $clog2(GRID_MAX + 1);
    localparam logic [22:0] AMP_LIMIT = 23'd4194304;

    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_RADIUS     = 3'd2;
    localparam logic [2:0] REG_STEP       = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SQ  = 3'd4;
    localparam logic [2:0] REG_PHASE_RATE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIDE, ST_POINT, ST_INSIDE, ST_DIST, ST_SQRT,
        ST_PHASE, ST_CORDIC, ST_ACC, ST_NEXT, ST_AMP_SQ, ST_AMP_SQRT,
        ST_INT_DIV, ST_DONE
    } psdp_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } psdp_sqrt_req_t;

    function automatic logic [31:0] atan_turns(input logic [3:0] i);
        case (i)
            4'd0:  atan_turns = 32'd536870912;
            4'd1:  atan_turns = 32'd316933406;
            4'd2:  atan_turns = 32'd167458907;
            4'd3:  atan_turns = 32'd85004756;
            4'd4:  atan_turns = 32'd42667332;
            4'd5:  atan_turns = 32'd21354465;
            4'd6:  atan_turns = 32'd10679838;
            4'd7:  atan_turns = 32'd5340245;
            4'd8:  atan_turns = 32'd2670163;
            4'd9:  atan_turns = 32'd1335087;
            4'd10: atan_turns = 32'd667544;
            4'd11: atan_turns = 32'd333772;
            4'd12: atan_turns = 32'd166886;
            4'd13: atan_turns = 32'd83443;
            4'd14: atan_turns = 32'd41721;
            default: atan_turns = 32'd20861;
        endcase
    endfunction
endpackage
`default_nettype wire

### rtl/psdp_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on psdp_pkg.
`default_nettype none
module psdp_isqrt (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire psdp_pkg::psdp_sqrt_req_t req,
    output logic                         done,
    output logic [31:0]                  root
);
    import psdp_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [33:0] part_reg, part_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] cand;
    logic [34:0] trial;

    // restoring digit recurrence: bring down two bits, try 4*root+1
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        part_next = part_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        cand      = 35'd0;
        trial     = 35'd0;
        if (req.start)
        begin
            rem_next  = req.value;
            root_next = 32'd0;
            part_next = 34'd0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // rem_reg holds the unconsumed radicand bits, top first
            cand  = {part_reg[32:0], rem_reg[63:62]};
            trial = {1'b0, root_reg, 2'b01};
            if (cand >= trial)
            begin
                part_next = 34'(cand - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                part_next = cand[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            rem_next  = {rem_reg[61:0], 2'b00};
            busy_next = (cnt_reg != 6'd31);
            cnt_next  = cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        part_reg <= part_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd31);
    assign root = root_next;
endmodule
`default_nettype wire

### rtl/psdp_cordic.sv
// Iterative rotation-mode CORDIC: 16 micro-rotations, one per cycle.
// Depends on psdp_pkg.
`default_nettype none
module psdp_cordic (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [psdp_pkg::PHASE_BITS-1:0] phase,
    output logic                                 done,
    output logic signed [15:0]                   sine,
    output logic signed [15:0]                   cosine
);
    import psdp_pkg::*;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [3:0]  it_reg, it_next;
    logic        busy_reg, busy_next, neg_reg, neg_next;
    logic signed [33:0] z0, xs, ys, xr, yr;

    function automatic logic signed [15:0] rc14(input logic signed [33:0] v,
                                                input logic neg);
        logic signed [33:0] t;
        begin
            t = (v + 34'sd128) >>> 8;
            if (t > 34'sd16384) t = 34'sd16384;
            if (t < -34'sd16384) t = -34'sd16384;
            if (neg) t = -t;
            rc14 = t[15:0];
        end
    endfunction

    always_comb
    begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        it_next = it_reg; busy_next = busy_reg; neg_next = neg_reg;
        // angle in 2^-32 turns, signed, folded to +-1/4 turn
        z0 = {{2{phase[PHASE_BITS-1]}}, phase, {(32-PHASE_BITS){1'b0}}};
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        xr = 34'sd0; yr = 34'sd0;
        if (start)
        begin
            neg_next = 1'b0;
            if (z0 > 34'sd1073741824)
            begin
                z0 = z0 - 34'sd2147483648; neg_next = 1'b1;
            end
            else if (z0 < -34'sd1073741824)
            begin
                z0 = z0 + 34'sd2147483648; neg_next = 1'b1;
            end
            x_next = 34'sd2547004; y_next = 34'sd0; z_next = z0;
            it_next = 4'd0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                xr = x_reg - ys; yr = y_reg + xs;
                z_next = z_reg - $signed({2'b00, atan_turns(it_reg)});
            end
            else
            begin
                xr = x_reg + ys; yr = y_reg - xs;
                z_next = z_reg + $signed({2'b00, atan_turns(it_reg)});
            end
            x_next = xr; y_next = yr;
            it_next = it_reg + 4'd1;
            busy_next = (it_reg != 4'd15);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; neg_reg <= neg_next;
    end

    // done marks the cycle after the last rotation
    logic fin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fin_reg <= 1'b0;
        else        fin_reg <= busy_reg && (it_reg == 4'd15);
    end

    assign done   = fin_reg;
    assign sine   = rc14(y_reg, neg_reg);
    assign cosine = rc14(x_reg, neg_reg);
endmodule
`default_nettype wire

### rtl/psdp_divider.sv
// Iterative unsigned restoring divider, 64/32, one quotient bit per cycle.
// Depends on psdp_pkg.
`default_nettype none
module psdp_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    import psdp_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] sh;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        sh = {r_reg[31:0], q_reg[63]};
        if (start)
        begin
            q_next = dividend; r_next = 33'd0; d_next = divisor;
            cnt_next = 7'd0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next  = cnt_reg + 7'd1;
            busy_next = (cnt_reg != 7'd63);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign done     = busy_reg && (cnt_reg == 7'd63);
    assign quotient = q_next;
endmodule
`default_nettype wire

### rtl/phasor_sum_diffraction_pixel.sv
// Diffraction pixel phasor sum: one pixel in, one result out after the grid walk.
// Sequencer plus shared sqrt and divider units and one CORDIC; depends on psdp_pkg.
//
// One pixel per start beat; busy stays high until the result beat. The grid side
// n = ceil(2r/step) (at most 256) is found by the divider. Each of the n*n grid
// points passes POINT, INSIDE and NEXT; one inside the disk also runs the square
// root and then the CORDIC, and the final magnitude adds a square root and, if
// any source was counted, a division. The result beat on done is one cycle wide
// and cannot be stalled; write configuration only while busy is low.
`default_nettype none
module phasor_sum_diffraction_pixel (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [24:0] cfg_data,
    input  wire logic        start,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    output logic             busy,
    output logic             done,
    output logic [22:0]      amplitude,
    output logic [4:0]       intensity,
    output logic [16:0]      source_count,
    output logic             grid_overflow
);
    import psdp_pkg::*;

    // configuration registers
    logic [24:0] cx_reg, cy_reg;
    logic [20:0] rad_reg;
    logic [16:0] step_reg;
    logic [15:0] hsq_reg;
    logic [23:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= 25'd4369067; cy_reg <= 25'd3495253; rad_reg <= 21'd43691;
            step_reg <= 17'd874; hsq_reg <= 16'd177; rate_reg <= 24'd39119;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:   cx_reg   <= cfg_data;
                REG_CENTER_Y:   cy_reg   <= cfg_data;
                REG_RADIUS:     rad_reg  <= cfg_data[20:0];
                REG_STEP:       step_reg <= cfg_data[16:0];
                REG_HEIGHT_SQ:  hsq_reg  <= cfg_data[15:0];
                REG_PHASE_RATE: rate_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    psdp_state_t st_reg, st_next;
    logic [9:0]  px_reg, py_reg;
    logic [GW-1:0] side_reg, side_next, col_reg, col_next, row_reg, row_next;
    logic        ovf_reg, ovf_next;
    logic signed [31:0] ssum_reg, ssum_next, csum_reg, csum_next;
    logic [16:0] cnt_reg, cnt_next;
    logic signed [39:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [11:0] mx_reg, mx_next, my_reg, my_next;
    logic [31:0] d1_reg, d1_next;
    logic [PHASE_BITS-1:0] ph_reg, ph_next;
    logic [22:0] amp_o_reg, amp_o_next;
    logic [4:0]  int_o_reg, int_o_next;
    logic [31:0] ampu_reg, ampu_next;
    logic        done_reg, done_next;

    // sqrt, CORDIC and divider units
    psdp_sqrt_req_t sq_req;
    logic        sq_done;
    logic [31:0] sq_root;
    logic        cd_start, cd_done;
    logic signed [15:0] cd_sin, cd_cos;
    logic        dv_start, dv_done;
    logic [63:0] dv_num, dv_q;
    logic [31:0] dv_den;
    logic        dv_start_all;

    psdp_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .done(sq_done),
                       .root(sq_root));
    psdp_cordic u_cordic (.clk(clk), .rst_n(rst_n), .start(cd_start), .phase(ph_reg),
                          .done(cd_done), .sine(cd_sin), .cosine(cd_cos));
    psdp_divider u_div (.clk(clk), .rst_n(rst_n), .start(dv_start_all), .dividend(dv_num),
                        .divisor(dv_den), .done(dv_done), .quotient(dv_q));

    logic [16:0] step_eff;
    logic signed [40:0] dxf, dyf;
    logic signed [21:0] oxs, oys;
    logic signed [42:0] rr, dd;
    logic [25:0] d2w;
    logic [47:0] prod;
    logic [GW-1:0] last;
    logic [63:0] sq_s, sq_c;

    assign step_eff = (step_reg == 17'd0) ? 17'd1 : step_reg;
    assign last     = side_reg - 1'b1;

    always_comb
    begin
        st_next = st_reg; side_next = side_reg; col_next = col_reg; row_next = row_reg;
        ovf_next = ovf_reg; ssum_next = ssum_reg; csum_next = csum_reg;
        cnt_next = cnt_reg; ox_next = ox_reg; oy_next = oy_reg;
        mx_next = mx_reg; my_next = my_reg;
        d1_next = d1_reg; ph_next = ph_reg;
        amp_o_next = amp_o_reg; int_o_next = int_o_reg; ampu_next = ampu_reg;
        done_next = 1'b0;
        sq_req = '{start: 1'b0, value: 64'd0};
        cd_start = 1'b0; dv_start = 1'b0;
        dv_num = {42'd0, rad_reg, 1'b0} + {47'd0, step_eff} - 64'd1;
        dv_den = {15'd0, step_eff};
        dxf = 41'sd0; dyf = 41'sd0; oxs = 22'sd0; oys = 22'sd0; d2w = 26'd0;
        rr = 43'sd0; dd = 43'sd0; prod = 48'd0; sq_s = 64'd0; sq_c = 64'd0;
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ssum_next = 32'sd0; csum_next = 32'sd0; cnt_next = 17'd0;
                    col_next = '0; row_next = '0;
                    dv_start = 1'b1;
                    st_next = ST_SIDE;
                end
            end
            // side = ceil(2r/step), clipped
            ST_SIDE:
            begin
                if (dv_done)
                begin
                    if (dv_q > 64'(GRID_MAX))
                    begin
                        side_next = GW'(GRID_MAX); ovf_next = 1'b1;
                    end
                    else
                    begin
                        side_next = dv_q[GW-1:0]; ovf_next = 1'b0;
                    end
                    ox_next = -$signed({19'd0, rad_reg});
                    oy_next = -$signed({19'd0, rad_reg});
                    st_next = (dv_q == 64'd0) ? ST_AMP_SQ : ST_POINT;
                end
            end
            // whole-pixel distances from the pixel to this source
            ST_POINT:
            begin
                dxf = $signed({15'd0, px_reg, 16'd0}) - ($signed({16'd0, cx_reg}) + ox_reg);
                dyf = $signed({15'd0, py_reg, 16'd0}) - ($signed({16'd0, cy_reg}) + oy_reg);
                mx_next = 12'((dxf < 0 ? -dxf : dxf) >>> 16);
                my_next = 12'((dyf < 0 ? -dyf : dyf) >>> 16);
                st_next = ST_INSIDE;
            end
            // exact disk test, offsets stay within +-r
            ST_INSIDE:
            begin
                oxs = ox_reg[21:0];
                oys = oy_reg[21:0];
                rr = 43'($signed({1'b0, rad_reg})) * 43'($signed({1'b0, rad_reg}));
                dd = 43'(oxs) * 43'(oxs) + 43'(oys) * 43'(oys);
                if (dd > rr) st_next = ST_NEXT;
                else         st_next = ST_DIST;
            end
            ST_DIST:
            begin
                d2w = {14'd0, mx_reg} * {14'd0, mx_reg} + {14'd0, my_reg} * {14'd0, my_reg}
                    + {10'd0, hsq_reg};
                sq_req = '{start: 1'b1, value: {22'd0, d2w, 16'd0}};
                st_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    d1_next = sq_root;
                    st_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                prod = 48'(d1_reg[23:0] * rate_reg);
                ph_next = prod[23 -: PHASE_BITS];
                st_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cd_start = 1'b1;
                st_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (cd_done)
                begin
                    ssum_next = ssum_reg + 32'(cd_sin);
                    csum_next = csum_reg + 32'(cd_cos);
                    cnt_next  = cnt_reg + 17'd1;
                    st_next   = ST_NEXT;
                end
            end
            // advance row, then column
            ST_NEXT:
            begin
                if (row_reg == last)
                begin
                    row_next = '0;
                    oy_next = -$signed({19'd0, rad_reg});
                    if (col_reg == last)
                    begin
                        col_next = '0;
                        st_next = ST_AMP_SQ;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        ox_next = ox_reg + $signed({23'd0, step_eff});
                        st_next = ST_POINT;
                    end
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    oy_next = oy_reg + $signed({23'd0, step_eff});
                    st_next = ST_POINT;
                end
            end
            // squared magnitude, square root launched at once
            ST_AMP_SQ:
            begin
                sq_s = 64'(ssum_reg) * 64'(ssum_reg);
                sq_c = 64'(csum_reg) * 64'(csum_reg);
                sq_req = '{start: 1'b1, value: (sq_s + sq_c) >> 12};
                st_next = ST_AMP_SQRT;
            end
            ST_AMP_SQRT:
            begin
                if (sq_done)
                begin
                    ampu_next = sq_root;
                    amp_o_next = (sq_root > {9'd0, AMP_LIMIT}) ? AMP_LIMIT : sq_root[22:0];
                    st_next = ST_INT_DIV;
                end
            end
            ST_INT_DIV:
            begin
                dv_num = {28'd0, ampu_reg, 4'd0};
                dv_den = {7'd0, cnt_reg, 8'd0};
                if (cnt_reg == 17'd0)
                begin
                    int_o_next = 5'd0;
                    st_next = ST_DONE;
                end
                else if (dv_done)
                begin
                    int_o_next = (dv_q > 64'd16) ? 5'd16 : dv_q[4:0];
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // launch the intensity division once on entry
    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) div_go_reg <= 1'b0;
        else        div_go_reg <= (st_reg == ST_AMP_SQRT) && sq_done;
    end

    assign dv_start_all = dv_start || (div_go_reg && (cnt_reg != 17'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; col_reg <= '0; row_reg <= '0;
            ssum_reg <= 32'sd0; csum_reg <= 32'sd0; cnt_reg <= 17'd0;
            done_reg <= 1'b0; ampu_reg <= 32'd0;
        end
        else
        begin
            st_reg <= st_next; col_reg <= col_next; row_reg <= row_next;
            ssum_reg <= ssum_next; csum_reg <= csum_next; cnt_reg <= cnt_next;
            done_reg <= done_next;
            ampu_reg <= ampu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            px_reg <= pixel_x; py_reg <= pixel_y;
        end
        side_reg <= side_next; ovf_reg <= ovf_next; ox_reg <= ox_next; oy_reg <= oy_next;
        mx_reg <= mx_next; my_reg <= my_next; d1_reg <= d1_next; ph_reg <= ph_next;
        amp_o_reg <= amp_o_next; int_o_reg <= int_o_next;
    end

    assign busy          = (st_reg != ST_IDLE);
    assign done          = done_reg;
    assign amplitude     = amp_o_reg;
    assign intensity     = int_o_reg;
    assign source_count  = cnt_reg;
    assign grid_overflow = ovf_reg;
endmodule
`default_nettype wire
